FILE: design/tpwa_pkg.sv
// Package for the tactile patch wrench accumulator.
// Holds widths, limits, register indexes and controller command/status types.
// No dependencies.
`default_nettype none
package tpwa_pkg;
  localparam int PosW   = 20;
  localparam int NrmW   = 16;
  localparam int RdW    = 24;
  localparam int ForceW = 40;
  localparam int MomW   = 44;
  localparam int IdxW   = 4;
  localparam int CfgW   = 32;
  localparam int CfgAW  = 1;
  localparam int MaxCells = 256;
  localparam int CntW   = $clog2(MaxCells + 1);

  localparam logic [CfgAW-1:0] RegForceScale = 1'b0;
  localparam logic [CfgAW-1:0] RegThreshold  = 1'b1;

  localparam logic signed [PosW-1:0] PosMax = {1'b0, {(PosW-1){1'b1}}};
  localparam logic signed [PosW-1:0] PosMin = {1'b1, {(PosW-1){1'b0}}};

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;       // capture input beat
    logic mul_gain;   // gain = scale * reading
    logic mul_force;  // cell force components
    logic mul_mom;    // cross products, then accumulate
    logic clear;      // clear frame state
    logic out_load;   // load output register with corner sel
    logic [1:0] corner;
    logic out_last;
  } tpwa_cmd_t;

  typedef struct packed {
    logic contact_seen;
  } tpwa_sts_t;
endpackage
`default_nettype wire

FILE: design/tpwa_datapath.sv
// Datapath: multipliers, saturating wrench sums, contact box, output register.
// Depends on tpwa_pkg; driven by tpwa_ctrl commands.
`default_nettype none
module tpwa_datapath (
  input  wire logic clk,
  input  wire tpwa_pkg::tpwa_cmd_t cmd,
  output tpwa_pkg::tpwa_sts_t sts,
  input  wire logic rst,
  input  wire logic [15:0] force_scale,
  input  wire logic signed [31:0] threshold,
  input  wire logic signed [19:0] pos_x, pos_y, pos_z,
  input  wire logic signed [15:0] normal_x, normal_y, normal_z,
  input  wire logic signed [23:0] force_reading,
  input  wire logic [3:0] sensor_index, patch_index,
  input  wire logic take,
  output logic signed [39:0] force_x, force_y, force_z,
  output logic signed [43:0] moment_x, moment_y, moment_z,
  output logic signed [19:0] corner_x, corner_y,
  output logic corner_valid, last_result,
  output logic [3:0] sensor_out, patch_out
);
  import tpwa_pkg::*;

  logic signed [PosW-1:0] px, py, pz;
  logic signed [NrmW-1:0] nx, ny, nz;
  logic signed [RdW-1:0] rd;
  logic [IdxW-1:0] sid, pid;
  logic take_r;
  logic signed [40:0] gain;
  logic signed [ForceW-1:0] fx, fy, fz;
  logic signed [60:0] cross_x, cross_y, cross_z;
  logic signed [ForceW-1:0] fsum [3];
  logic signed [MomW-1:0] msum [3];
  logic signed [PosW-1:0] mnx, mny, mxx, mxy;
  logic seen;

  function automatic logic signed [ForceW-1:0] sat_f(input logic signed [57:0] v);
    if (v > 58'sd549755813887) return {1'b0, {(ForceW-1){1'b1}}};
    if (v < -58'sd549755813888) return {1'b1, {(ForceW-1){1'b0}}};
    return v[ForceW-1:0];
  endfunction

  function automatic logic signed [MomW-1:0] sat_m(input logic signed [MomW:0] v);
    if (v[MomW] != v[MomW-1]) return {v[MomW], {(MomW-1){~v[MomW]}}};
    return v[MomW-1:0];
  endfunction

  // Products of the cross step; each 20x40 multiply is registered separately
  // from its use in the difference.
  logic signed [59:0] pa, pb, pc, pd, pe, pf;
  logic signed [57:0] fgx, fgy, fgz;
  assign fgx = 58'(gain * nx) >>> 8;
  assign fgy = 58'(gain * ny) >>> 8;
  assign fgz = 58'(gain * nz) >>> 8;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px <= pos_x; py <= pos_y; pz <= pos_z;
      nx <= normal_x; ny <= normal_y; nz <= normal_z;
      rd <= force_reading; sid <= sensor_index; pid <= patch_index;
      take_r <= take;
    end
    if (cmd.mul_gain) gain <= $signed({1'b0, force_scale}) * rd;
    if (cmd.mul_force) begin
      fx <= sat_f(fgx); fy <= sat_f(fgy); fz <= sat_f(fgz);
    end
    if (cmd.mul_mom) begin
      pa <= py * fz; pb <= pz * fy;
      pc <= pz * fx; pd <= px * fz;
      pe <= px * fy; pf <= py * fx;
    end
  end
  assign cross_x = 61'(pa) - 61'(pb);
  assign cross_y = 61'(pc) - 61'(pd);
  assign cross_z = 61'(pe) - 61'(pf);

  // Accumulate in the cycle after the products are registered (cmd.mul_mom delayed).
  logic acc;
  logic signed [44:0] mx_c, my_c, mz_c;
  assign mx_c = 45'(msum[0]) + 45'(cross_x >>> 16);
  assign my_c = 45'(msum[1]) + 45'(cross_y >>> 16);
  assign mz_c = 45'(msum[2]) + 45'(cross_z >>> 16);
  logic signed [40:0] fx_c, fy_c, fz_c;
  assign fx_c = 41'(fsum[0]) + 41'(fx);
  assign fy_c = 41'(fsum[1]) + 41'(fy);
  assign fz_c = 41'(fsum[2]) + 41'(fz);
  logic hit;
  assign hit = 41'(fz) > 41'(threshold);

  always_ff @(posedge clk) begin
    if (rst) acc <= 1'b0;
    else acc <= cmd.mul_mom;
    if (rst || cmd.clear) begin
      for (int i = 0; i < 3; i++) begin
        fsum[i] <= '0; msum[i] <= '0;
      end
      mnx <= PosMax; mny <= PosMax; mxx <= PosMin; mxy <= PosMin;
      seen <= 1'b0;
    end else if (acc && take_r) begin
      fsum[0] <= sat_f(58'(fx_c)); fsum[1] <= sat_f(58'(fy_c));
      fsum[2] <= sat_f(58'(fz_c));
      msum[0] <= sat_m(mx_c); msum[1] <= sat_m(my_c); msum[2] <= sat_m(mz_c);
      if (hit) begin
        seen <= 1'b1;
        if (px < mnx) mnx <= px;
        if (py < mny) mny <= py;
        if (px > mxx) mxx <= px;
        if (py > mxy) mxy <= py;
      end
    end
  end
  assign sts.contact_seen = seen;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      force_x <= fsum[0]; force_y <= fsum[1]; force_z <= fsum[2];
      moment_x <= msum[0]; moment_y <= msum[1]; moment_z <= msum[2];
      corner_valid <= seen;
      last_result <= cmd.out_last;
      sensor_out <= sid; patch_out <= pid;
      if (!seen) begin
        corner_x <= '0; corner_y <= '0;
      end else begin
        case (cmd.corner)
          2'd0: begin corner_x <= mxx; corner_y <= mxy; end
          2'd1: begin corner_x <= mnx; corner_y <= mxy; end
          2'd2: begin corner_x <= mnx; corner_y <= mny; end
          default: begin corner_x <= mxx; corner_y <= mny; end
        endcase
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/tpwa_ctrl.sv
// Controller: sequences one cell through the datapath and emits results.
// Depends on tpwa_pkg.
`default_nettype none
module tpwa_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic last_cell,
  output logic out_valid,
  input  wire logic out_ready,
  output logic take,
  output tpwa_pkg::tpwa_cmd_t cmd,
  input  wire tpwa_pkg::tpwa_sts_t sts
);
  import tpwa_pkg::*;

  localparam logic [2:0] SIdle = 3'd0, SGain = 3'd1, SForce = 3'd2, SMom = 3'd3,
                         SAcc = 3'd4, SEmit = 3'd5, SWait = 3'd6;

  logic [2:0] state, state_next;
  logic [CntW-1:0] count;
  logic last_r;
  logic [1:0] corner;
  logic accept;

  assign in_ready = (state == SIdle);
  assign accept = in_valid && in_ready;
  assign take = (count < CntW'(MaxCells));

  always_comb begin
    cmd = '0;
    state_next = state;
    cmd.corner = corner;
    cmd.out_last = !sts.contact_seen || (corner == 2'd3);
    case (state)
      SIdle: if (accept) begin cmd.load = 1'b1; state_next = SGain; end
      SGain: begin cmd.mul_gain = 1'b1; state_next = SForce; end
      SForce: begin cmd.mul_force = 1'b1; state_next = SMom; end
      SMom: begin cmd.mul_mom = 1'b1; state_next = SAcc; end
      SAcc: state_next = last_r ? SEmit : SIdle;
      SEmit: if (!out_valid || out_ready) begin
        cmd.out_load = 1'b1; state_next = SWait;
      end
      SWait: if (out_ready) begin
        if (cmd.out_last) begin cmd.clear = 1'b1; state_next = SIdle; end
        else state_next = SEmit;
      end
      default: state_next = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle; count <= '0; last_r <= 1'b0; corner <= '0; out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        last_r <= last_cell;
        if (take) count <= count + 1'b1;
      end
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (state == SWait && out_ready) corner <= cmd.out_last ? 2'd0 : corner + 2'd1;
      if (cmd.clear) count <= '0;
    end
  end
endmodule
`default_nettype wire

FILE: design/tactile_patch_wrench_accumulator_unit.sv
// Top level of the tactile patch wrench accumulator.
// Depends on tpwa_pkg, tpwa_ctrl and tpwa_datapath.
//
// channel  | handshake               | payload
// in       | in_valid / in_ready     | pos, normal, force_reading, last_cell, indexes
// out      | out_valid / out_ready   | wrench, corner, flags, echoes
// cfg      | cfg_we                  | cfg_index, cfg_data
//
// A cell goes through capture, gain multiply, force multiply, cross products
// and accumulate. A last cell adds emit and wait states per result beat
// (one or four beats) plus the downstream stall. Reset is synchronous and
// clears sums, box and count. A stalled output holds the controller.
`default_nettype none
module tactile_patch_wrench_accumulator_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic signed [19:0] pos_x, pos_y, pos_z,
  input  wire logic signed [15:0] normal_x, normal_y, normal_z,
  input  wire logic signed [23:0] force_reading,
  input  wire logic last_cell,
  input  wire logic [3:0] sensor_index, patch_index,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [39:0] force_x, force_y, force_z,
  output logic signed [43:0] moment_x, moment_y, moment_z,
  output logic signed [19:0] corner_x, corner_y,
  output logic corner_valid, last_result,
  output logic [3:0] sensor_out, patch_out
);
  import tpwa_pkg::*;

  logic [15:0] force_scale;
  logic signed [31:0] threshold;
  tpwa_cmd_t cmd;
  tpwa_sts_t sts;
  logic take;

  always_ff @(posedge clk) begin
    if (rst) begin
      force_scale <= 16'd256; threshold <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegForceScale: force_scale <= cfg_data[15:0];
        RegThreshold: threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  tpwa_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .last_cell, .out_valid, .out_ready,
    .take, .cmd, .sts
  );

  tpwa_datapath u_dp (
    .clk, .cmd, .sts, .rst, .force_scale, .threshold,
    .pos_x, .pos_y, .pos_z, .normal_x, .normal_y, .normal_z, .force_reading,
    .sensor_index, .patch_index, .take,
    .force_x, .force_y, .force_z, .moment_x, .moment_y, .moment_z,
    .corner_x, .corner_y, .corner_valid, .last_result, .sensor_out, .patch_out
  );

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken during result output");
  a_invalid_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !corner_valid) |-> last_result) else $error("empty result not last");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !corner_valid) |-> (corner_x == '0 && corner_y == '0))
    else $error("empty result corner nonzero");
endmodule
`default_nettype wire
